@@ sv/indexed_conveyor_step_controller_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the conveyor step controller
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_CONVEYOR_STEP_CONTROLLER_TOP_ASSERT_SVH
`define INDEXED_CONVEYOR_STEP_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define ICSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icsc assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ICSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icsc assertion failed");

`endif

@@ sv/icsc_pkg.sv @@
// ----------------------------------------------------------------------------
// icsc_pkg
// Types, codes and constants shared by the conveyor step controller.
// ----------------------------------------------------------------------------
package icsc_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned ReplyW  = 3;
  localparam int unsigned FaultW  = 2;
  localparam int unsigned RunW    = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [TickW-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [TickW-1:0] TICK_MAX      = 16'hFFFF;

  localparam logic [ReqW-1:0] REQ_NONE     = 3'd0;
  localparam logic [ReqW-1:0] REQ_IDENTIFY = 3'd1;
  localparam logic [ReqW-1:0] REQ_SET_FWD  = 3'd2;
  localparam logic [ReqW-1:0] REQ_SET_REV  = 3'd3;
  localparam logic [ReqW-1:0] REQ_GO       = 3'd4;
  localparam logic [ReqW-1:0] REQ_ESTOP    = 3'd5;
  localparam logic [ReqW-1:0] REQ_STATUS   = 3'd6;

  localparam logic [ReplyW-1:0] RPL_NONE     = 3'd0;
  localparam logic [ReplyW-1:0] RPL_IDENTITY = 3'd1;
  localparam logic [ReplyW-1:0] RPL_FWD_ACK  = 3'd2;
  localparam logic [ReplyW-1:0] RPL_REV_ACK  = 3'd3;
  localparam logic [ReplyW-1:0] RPL_BUSY     = 3'd4;
  localparam logic [ReplyW-1:0] RPL_GO_ACK   = 3'd5;
  localparam logic [ReplyW-1:0] RPL_ESTOP    = 3'd6;
  localparam logic [ReplyW-1:0] RPL_STATUS   = 3'd7;

  localparam logic [FaultW-1:0] FLT_NONE    = 2'd0;
  localparam logic [FaultW-1:0] FLT_OCCLUDE = 2'd1;
  localparam logic [FaultW-1:0] FLT_CLEAR   = 2'd2;

  localparam logic [RunW-1:0] RUN_IDLE    = 2'd0;
  localparam logic [RunW-1:0] RUN_WORKING = 2'd1;
  localparam logic [RunW-1:0] RUN_FAULT   = 2'd2;
  localparam logic [RunW-1:0] RUN_ESTOP   = 2'd3;

  localparam logic ADDR_OCCLUDE = 1'b0;
  localparam logic ADDR_CLEAR   = 1'b1;

  localparam int unsigned LINE_EN = 0;
  localparam int unsigned LINE_A  = 1;
  localparam int unsigned LINE_B  = 2;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WORKING = 4'b0010,
    MODE_FAULT   = 4'b0100,
    MODE_ESTOP   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic            beam_blocked;
    logic            fwd_button;
    logic            rev_button;
  } item_t;

  typedef struct packed {
    logic              motor_enable;
    logic              bridge_in_a;
    logic              bridge_in_b;
    logic [RunW-1:0]   run_state;
    logic              direction;
    logic [ReplyW-1:0] reply;
    logic [FaultW-1:0] fault;
  } res_t;

  typedef struct packed {
    logic [TickW-1:0] occlude_timeout;
    logic [TickW-1:0] clear_timeout;
  } cfg_t;

  function automatic logic [RunW-1:0] run_code(mode_t m);
    logic [RunW-1:0] code;
    unique case (m)
      MODE_IDLE:    code = RUN_IDLE;
      MODE_WORKING: code = RUN_WORKING;
      MODE_FAULT:   code = RUN_FAULT;
      MODE_ESTOP:   code = RUN_ESTOP;
      default:      code = RUN_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ sv/icsc_in_if.sv @@
// ----------------------------------------------------------------------------
// icsc_in_if
// Input channel: one tick item per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface icsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [icsc_pkg::ReqW-1:0]   req_type;
  logic                        beam_blocked;
  logic                        fwd_button;
  logic                        rev_button;

  modport source (output valid, output req_type, output beam_blocked,
                  output fwd_button, output rev_button, input ready);
  modport sink   (input valid, input req_type, input beam_blocked,
                  input fwd_button, input rev_button, output ready);
endinterface

@@ sv/icsc_out_if.sv @@
// ----------------------------------------------------------------------------
// icsc_out_if
// Result channel: one controller result per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface icsc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          motor_enable;
  logic                          bridge_in_a;
  logic                          bridge_in_b;
  logic [icsc_pkg::RunW-1:0]     run_state;
  logic                          direction;
  logic [icsc_pkg::ReplyW-1:0]   reply;
  logic [icsc_pkg::FaultW-1:0]   fault;

  modport source (output valid, output motor_enable, output bridge_in_a,
                  output bridge_in_b, output run_state, output direction,
                  output reply, output fault, input ready);
  modport sink   (input valid, input motor_enable, input bridge_in_a,
                  input bridge_in_b, input run_state, input direction,
                  input reply, input fault, output ready);
endinterface

@@ sv/icsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// icsc_cfg_regs
// APB-style register file holding the occlude and clear timeouts.
// ----------------------------------------------------------------------------
module icsc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icsc_pkg::AddrW-1:0]   paddr,
  input  logic [icsc_pkg::DataW-1:0]   pwdata,
  output logic [icsc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output icsc_pkg::cfg_t               cfg
);

  logic [icsc_pkg::TickW-1:0] occ_r;
  logic [icsc_pkg::TickW-1:0] clr_r;
  logic                       wr_en;
  logic                       sel;

  assign pready = 1'b1;
  assign sel    = paddr[2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= icsc_pkg::TIMEOUT_RESET;
      clr_r <= icsc_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      if (sel == icsc_pkg::ADDR_OCCLUDE) begin
        occ_r <= pwdata[icsc_pkg::TickW-1:0];
      end else begin
        clr_r <= pwdata[icsc_pkg::TickW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      icsc_pkg::ADDR_OCCLUDE: prdata[icsc_pkg::TickW-1:0] = occ_r;
      icsc_pkg::ADDR_CLEAR:   prdata[icsc_pkg::TickW-1:0] = clr_r;
      default:                prdata = '0;
    endcase
  end

  assign cfg.occlude_timeout = occ_r;
  assign cfg.clear_timeout   = clr_r;

endmodule

@@ sv/icsc_step.sv @@
// ----------------------------------------------------------------------------
// icsc_step
// Controller state and the single-pass command, button and run-state step.
// ----------------------------------------------------------------------------
`include "indexed_conveyor_step_controller_top_assert.svh"

module icsc_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  icsc_pkg::item_t  item,
  input  icsc_pkg::cfg_t   cfg,
  output icsc_pkg::res_t   res
);

  icsc_pkg::mode_t             mode_r, mode_nxt;
  logic                        dir_r, dir_nxt;
  logic                        start_r, start_nxt;
  logic                        seen_r, seen_nxt;
  logic [icsc_pkg::TickW-1:0]  tick_r, tick_nxt;
  logic [2:0]                  drive_r, drive_nxt;
  logic [icsc_pkg::ReplyW-1:0] reply;
  logic [icsc_pkg::FaultW-1:0] fault;

  always_comb begin
    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    start_nxt = start_r;
    seen_nxt  = seen_r;
    tick_nxt  = tick_r;
    drive_nxt = drive_r;
    reply     = icsc_pkg::RPL_NONE;
    fault     = icsc_pkg::FLT_NONE;

    unique case (item.req_type)
      icsc_pkg::REQ_IDENTIFY: reply = icsc_pkg::RPL_IDENTITY;
      icsc_pkg::REQ_SET_FWD, icsc_pkg::REQ_SET_REV: begin
        if (mode_r == icsc_pkg::MODE_WORKING) begin
          reply = icsc_pkg::RPL_BUSY;
        end else begin
          dir_nxt = (item.req_type == icsc_pkg::REQ_SET_REV);
          reply   = (item.req_type == icsc_pkg::REQ_SET_REV) ?
                    icsc_pkg::RPL_REV_ACK : icsc_pkg::RPL_FWD_ACK;
        end
      end
      icsc_pkg::REQ_GO: begin
        if (mode_r == icsc_pkg::MODE_WORKING) begin
          reply = icsc_pkg::RPL_BUSY;
        end else begin
          mode_nxt = icsc_pkg::MODE_WORKING;
          reply    = icsc_pkg::RPL_GO_ACK;
        end
      end
      icsc_pkg::REQ_ESTOP: begin
        mode_nxt = icsc_pkg::MODE_ESTOP;
        reply    = icsc_pkg::RPL_ESTOP;
      end
      icsc_pkg::REQ_STATUS: reply = icsc_pkg::RPL_STATUS;
      default: reply = icsc_pkg::RPL_NONE;
    endcase

    // Forward wins when both buttons are pressed.
    if (item.fwd_button && mode_nxt == icsc_pkg::MODE_IDLE) begin
      dir_nxt  = 1'b0;
      mode_nxt = icsc_pkg::MODE_WORKING;
    end else if (item.rev_button && mode_nxt == icsc_pkg::MODE_IDLE) begin
      dir_nxt  = 1'b1;
      mode_nxt = icsc_pkg::MODE_WORKING;
    end

    if (mode_nxt == icsc_pkg::MODE_WORKING) begin
      drive_nxt = '0;
      drive_nxt[icsc_pkg::LINE_EN] = 1'b1;
      drive_nxt[icsc_pkg::LINE_A]  = !dir_nxt;
      drive_nxt[icsc_pkg::LINE_B]  = dir_nxt;
      if (start_r) begin
        tick_nxt  = '0;
        start_nxt = 1'b0;
      end else if (tick_r != icsc_pkg::TICK_MAX) begin
        tick_nxt = tick_r + icsc_pkg::TickW'(1);
      end
      if (seen_r) begin
        if (!item.beam_blocked) begin
          drive_nxt[icsc_pkg::LINE_A] = 1'b0;
          drive_nxt[icsc_pkg::LINE_B] = 1'b0;
          seen_nxt  = 1'b0;
          start_nxt = 1'b1;
          mode_nxt  = icsc_pkg::MODE_IDLE;
        end else if (tick_nxt >= cfg.clear_timeout) begin
          fault     = icsc_pkg::FLT_CLEAR;
          seen_nxt  = 1'b0;
          start_nxt = 1'b1;
          mode_nxt  = icsc_pkg::MODE_FAULT;
        end
      end else begin
        if (item.beam_blocked) begin
          seen_nxt = 1'b1;
          tick_nxt = '0;
        end else if (tick_nxt >= cfg.occlude_timeout) begin
          fault     = icsc_pkg::FLT_OCCLUDE;
          start_nxt = 1'b1;
          mode_nxt  = icsc_pkg::MODE_FAULT;
        end
      end
    end else if (mode_nxt == icsc_pkg::MODE_FAULT || mode_nxt == icsc_pkg::MODE_ESTOP) begin
      drive_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= icsc_pkg::MODE_IDLE;
      dir_r   <= 1'b0;
      start_r <= 1'b1;
      seen_r  <= 1'b0;
      tick_r  <= '0;
      drive_r <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      dir_r   <= dir_nxt;
      start_r <= start_nxt;
      seen_r  <= seen_nxt;
      tick_r  <= tick_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign res.motor_enable = drive_nxt[icsc_pkg::LINE_EN];
  assign res.bridge_in_a  = drive_nxt[icsc_pkg::LINE_A];
  assign res.bridge_in_b  = drive_nxt[icsc_pkg::LINE_B];
  assign res.run_state    = icsc_pkg::run_code(mode_nxt);
  assign res.direction    = dir_nxt;
  assign res.reply        = reply;
  assign res.fault        = fault;

  `ICSC_ASSERT_NEXT(a_fault_latches,
                    step_en && fault != icsc_pkg::FLT_NONE,
                    mode_r == icsc_pkg::MODE_FAULT)
  `ICSC_ASSERT_NEXT(a_stop_lines_low,
                    step_en && fault == icsc_pkg::FLT_NONE &&
                    (mode_nxt == icsc_pkg::MODE_FAULT || mode_nxt == icsc_pkg::MODE_ESTOP),
                    drive_r == 3'b000)
  `ICSC_ASSERT_NEXT(a_working_enabled,
                    step_en && mode_nxt == icsc_pkg::MODE_WORKING,
                    drive_r[icsc_pkg::LINE_EN])
  `ICSC_ASSERT_NEXT(a_tick_holds, !step_en, tick_r == $past(tick_r))
  `ICSC_ASSERT_SAME(a_drive_one_side, 1'b1,
                    !(drive_r[icsc_pkg::LINE_A] && drive_r[icsc_pkg::LINE_B]))

endmodule

@@ sv/indexed_conveyor_step_controller_top.sv @@
// An accepted beat goes to the input register, then the result register, which drives out_ch.valid.
// One item per cycle unless out_ch stalls; the step sits between the input and result registers.
// While a result waits, an empty input register still takes one item, then the input stalls.
// Reset (rst_n low at a clock edge) empties both registers and sets idle, forward, 500-tick timeouts.
// ----------------------------------------------------------------------------
// indexed_conveyor_step_controller_top
// One-step indexing conveyor controller with input register, step logic,
// result register and APB-style timeout registers.
// ----------------------------------------------------------------------------
module indexed_conveyor_step_controller_top (
  input  logic                         clk,
  input  logic                         rst_n,
  icsc_in_if.sink                      in_ch,
  icsc_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [icsc_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [icsc_pkg::DataW-1:0]   cfg_pwdata,
  output logic [icsc_pkg::DataW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  icsc_pkg::cfg_t  cfg;
  icsc_pkg::item_t item_r;
  icsc_pkg::res_t  res;
  icsc_pkg::res_t  res_r;
  logic            item_vld_r;
  logic            res_vld_r;
  logic            adv;
  logic            step_en;
  logic            in_fire;

  icsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign adv          = !res_vld_r || out_ch.ready;
  assign step_en      = item_vld_r && adv;
  assign in_ch.ready  = !item_vld_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type     <= in_ch.req_type;
      item_r.beam_blocked <= in_ch.beam_blocked;
      item_r.fwd_button   <= in_ch.fwd_button;
      item_r.rev_button   <= in_ch.rev_button;
    end
  end

  icsc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = res_vld_r;
  assign out_ch.motor_enable = res_r.motor_enable;
  assign out_ch.bridge_in_a  = res_r.bridge_in_a;
  assign out_ch.bridge_in_b  = res_r.bridge_in_b;
  assign out_ch.run_state    = res_r.run_state;
  assign out_ch.direction    = res_r.direction;
  assign out_ch.reply        = res_r.reply;
  assign out_ch.fault        = res_r.fault;

endmodule
